>>> rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Types, constants and step functions for the quaternion to Euler angle
// pipeline: CORDIC lane, pipeline words, arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int XY_W = 36;
   localparam int Z_W  = 35;
   localparam int V_W  = 61;
   localparam int S_W  = 32;
   localparam int SQRT_STEPS = 31;

   localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
   localparam logic signed [S_W-1:0] ONE_Q30  = 32'sd1073741824;

   localparam logic [29:0] ATAN_TAB [0:31] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
      30'h00000001, 30'h00000000
   };

   typedef struct packed {
      logic                    zero;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } lane_type;

   typedef struct packed {
      lane_type                roll;
      lane_type                yaw;
      logic signed [S_W-1:0]   s;
      logic                    clamped;
      logic [V_W-1:0]          v;
      logic [V_W-1:0]          r;
   } sqrt_word_type;

   typedef struct packed {
      lane_type                roll;
      lane_type                yaw;
      lane_type                pitch;
      logic                    clamped;
   } cordic_word_type;

   // zero test and turn by pi for a negative real part
   function automatic lane_type lane_prerot(logic signed [XY_W-1:0] y,
                                             logic signed [XY_W-1:0] x);
      lane_type l;
      l.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         l.x = -x;
         l.y = -y;
         l.z = (y >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         l.x = x;
         l.y = y;
         l.z = '0;
      end
      return l;
   endfunction

   function automatic lane_type lane_iter(lane_type a, int sh);
      lane_type l;
      logic signed [Z_W-1:0] t;
      t = Z_W'(ATAN_TAB[sh[4:0]]);
      l = a;
      if (a.y >= 0) begin
         l.x = a.x + (a.y >>> sh);
         l.y = a.y - (a.x >>> sh);
         l.z = a.z + t;
      end else begin
         l.x = a.x - (a.y >>> sh);
         l.y = a.y + (a.x >>> sh);
         l.z = a.z - t;
      end
      return l;
   endfunction

   function automatic logic signed [17:0] lane_final(lane_type l,
                                                     logic signed [17:0] lim);
      logic signed [Z_W-1:0] zr;
      logic signed [17:0] r;
      zr = (l.z + Z_W'(65536)) >>> 17;
      r  = zr[17:0];
      if (l.zero)
         r = '0;
      else if (r > lim)
         r = lim;
      else if (r < -lim)
         r = -lim;
      return r;
   endfunction

endpackage

>>> rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion (Q1.15) to ZYX Euler angles (Q3.13 rad, pitch Q2.13) through a chain of
// square root cells and CORDIC cells.
// Throughput: one transaction per cycle; the whole chain holds while the
// output register is full and stalled.
// Reset clears the valid bits only; no other state.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);

   localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // products
   logic               p_valid_ff;
   logic signed [31:0] zy_ff, wx_ff, xx_ff, yy_ff, zw_ff, xy_ff, yw_ff, zx_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (reset)
         p_valid_ff <= 1'b0;
      else if (adv)
         p_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zy_ff <= req_quat_z * req_quat_y;
         wx_ff <= req_quat_w * req_quat_x;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zw_ff <= req_quat_z * req_quat_w;
         xy_ff <= req_quat_x * req_quat_y;
         yw_ff <= req_quat_y * req_quat_w;
         zx_ff <= req_quat_z * req_quat_x;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // sums, saturation of the pitch argument
   logic                   a_valid_ff;
   lane_type               a_roll_ff, a_roll_in, a_yaw_ff, a_yaw_in;
   logic signed [S_W-1:0]  a_s_ff, a_s_in;
   logic [30:0]            a_sa_ff, a_sa_in;
   logic                   a_clamp_ff, a_clamp_in;
   logic signed [XY_W-1:0] s_full;

   always_comb begin
      a_roll_in   = '0;
      a_yaw_in    = '0;
      a_roll_in.y = (XY_W'(zy_ff) + XY_W'(wx_ff)) <<< 1;
      a_roll_in.x = XY_W'(ONE_Q30) - ((XY_W'(xx_ff) + XY_W'(yy_ff)) <<< 1);
      a_yaw_in.y  = (XY_W'(zw_ff) + XY_W'(xy_ff)) <<< 1;
      a_yaw_in.x  = XY_W'(ONE_Q30) - ((XY_W'(yy_ff) + XY_W'(zz_ff)) <<< 1);
      s_full      = (XY_W'(yw_ff) - XY_W'(zx_ff)) <<< 1;
      a_clamp_in  = 1'b0;
      if (s_full > XY_W'(ONE_Q30)) begin
         a_s_in     = ONE_Q30;
         a_clamp_in = 1'b1;
      end else if (s_full < -XY_W'(ONE_Q30)) begin
         a_s_in     = -ONE_Q30;
         a_clamp_in = 1'b1;
      end else begin
         a_s_in = s_full[S_W-1:0];
      end
      a_sa_in = (a_s_in < 0) ? 31'(-a_s_in) : 31'(a_s_in);
   end

   always_ff @(posedge clock) begin
      if (reset)
         a_valid_ff <= 1'b0;
      else if (adv)
         a_valid_ff <= p_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_roll_ff  <= a_roll_in;
         a_yaw_ff   <= a_yaw_in;
         a_s_ff     <= a_s_in;
         a_sa_ff    <= a_sa_in;
         a_clamp_ff <= a_clamp_in;
      end
   end

   // 1 - s^2 in Q.60
   logic          b_valid_ff;
   sqrt_word_type b_word_ff, b_word_in;
   logic [61:0]   sq;

   always_comb begin
      sq                = a_sa_ff * a_sa_ff;
      b_word_in.roll    = a_roll_ff;
      b_word_in.yaw     = a_yaw_ff;
      b_word_in.s       = a_s_ff;
      b_word_in.clamped = a_clamp_ff;
      b_word_in.v       = V_W'((62'(1) << 60) - sq);
      b_word_in.r       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         b_valid_ff <= 1'b0;
      else if (adv)
         b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv)
         b_word_ff <= b_word_in;
   end

   // square root chain
   logic          sq_valid [0:SQRT_STEPS];
   sqrt_word_type sq_word  [0:SQRT_STEPS];

   assign sq_valid[0] = b_valid_ff;
   assign sq_word[0]  = b_word_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      qte_sqrt_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (adv),
         .in_valid  (sq_valid[k]),
         .in_word   (sq_word[k]),
         .out_valid (sq_valid[k+1]),
         .out_word  (sq_word[k+1])
      );
   end

   // quadrant correction
   logic            c_valid_ff;
   cordic_word_type c_word_ff, c_word_in;
   sqrt_word_type   sq_last;

   always_comb begin
      sq_last           = sq_word[SQRT_STEPS];
      c_word_in.roll    = lane_prerot(sq_last.roll.y, sq_last.roll.x);
      c_word_in.yaw     = lane_prerot(sq_last.yaw.y, sq_last.yaw.x);
      c_word_in.pitch   = lane_prerot(XY_W'(sq_last.s), XY_W'(sq_last.r));
      c_word_in.clamped = sq_last.clamped;
   end

   always_ff @(posedge clock) begin
      if (reset)
         c_valid_ff <= 1'b0;
      else if (adv)
         c_valid_ff <= sq_valid[SQRT_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv)
         c_word_ff <= c_word_in;
   end

   // CORDIC chain
   logic            cr_valid [0:N];
   cordic_word_type cr_word  [0:N];

   assign cr_valid[0] = c_valid_ff;
   assign cr_word[0]  = c_word_ff;

   for (genvar i = 0; i < N; i++) begin : g_cordic
      qte_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (adv),
         .in_valid  (cr_valid[i]),
         .in_word   (cr_word[i]),
         .out_valid (cr_valid[i+1]),
         .out_word  (cr_word[i+1])
      );
   end

   // rounding and output register
   logic               rsp_valid_ff;
   logic signed [15:0] roll_ff, yaw_ff;
   logic signed [14:0] pitch_ff;
   logic               clamp_ff;
   logic signed [17:0] roll_r, yaw_r, pitch_r;

   always_comb begin
      roll_r  = lane_final(cr_word[N].roll, PI_Q13);
      yaw_r   = lane_final(cr_word[N].yaw, PI_Q13);
      pitch_r = lane_final(cr_word[N].pitch, HALF_PI_Q13);
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= cr_valid[N];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_r[15:0];
         yaw_ff   <= yaw_r[15:0];
         pitch_ff <= pitch_r[14:0];
         clamp_ff <= cr_word[N].clamped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_pitch_clamped = clamp_ff;

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd25736 && rsp_roll_angle >= -16'sd25736))
      else $error("roll out of range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= 16'sd25736 && rsp_yaw_angle >= -16'sd25736))
      else $error("yaw out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868))
      else $error("pitch out of range");

   a_clamp_pole: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
         (rsp_pitch_angle >= 15'sd12700 || rsp_pitch_angle <= -15'sd12700))
      else $error("saturated pitch argument not at a pole");

endmodule

>>> rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit of the restoring square root of 1 - s^2, with the roll and
// yaw vectors carried along.
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  sqrt_word_type in_word,
   output logic          out_valid,
   output sqrt_word_type out_word
);

   localparam logic [V_W-1:0] BIT = V_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

   logic          valid_ff;
   sqrt_word_type word_ff, word_in;
   logic [V_W-1:0] trial;

   always_comb begin
      word_in = in_word;
      trial   = in_word.r + BIT;
      if (in_word.v >= trial) begin
         word_in.v = in_word.v - trial;
         word_in.r = (in_word.r >> 1) + BIT;
      end else begin
         word_in.r = in_word.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (enable)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (enable)
         word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation for the roll, yaw and pitch lanes.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  cordic_word_type in_word,
   output logic            out_valid,
   output cordic_word_type out_word
);

   logic            valid_ff;
   cordic_word_type word_ff, word_in;

   always_comb begin
      word_in       = in_word;
      word_in.roll  = lane_iter(in_word.roll, STEP);
      word_in.yaw   = lane_iter(in_word.yaw, STEP);
      word_in.pitch = lane_iter(in_word.pitch, STEP);
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (enable)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (enable)
         word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> sim/quaternion_to_euler_angles_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Self-checking bench for the quaternion to Euler angle pipeline. A driver
// feeds quaternions from a pending queue, an angle predictor works out roll,
// pitch, yaw and the clamp flag per transaction, and a monitor checks each
// response in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb import qte_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS     = 16;
   localparam int LATENCY   = 36 + STEPS;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle;
   logic rsp_pitch_clamped;

   quat_type   pending_quats[$];
   angles_type expected_angles[$];
   int         mismatches = 0;
   int         cycles = 0;
   int         req_gap = 0, rsp_gap = 0;
   bit         quiet = 1'b0;

   quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) u_dut (.*);

   always #10 clock = ~clock;

   function automatic longint atan2_q13(longint y, longint x, longint lim);
      longint z, r, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[i[4:0]]);
         end else begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[i[4:0]]);
         end
      end
      r = (z + 65536) >>> 17;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic angles_type euler_of(quat_type q);
      longint w, x, y, z, s, c, one;
      longint unsigned sa;
      angles_type a;
      w = q.w; x = q.x; y = q.y; z = q.z;
      one = 64'sd1 << 30;
      a.roll = 16'(atan2_q13(2 * (z * y + w * x), one - 2 * (x * x + y * y), 25736));
      a.yaw  = 16'(atan2_q13(2 * (z * w + x * y), one - 2 * (y * y + z * z), 25736));
      s = 2 * (y * w - z * x);
      a.clamped = 1'b0;
      if (s > one) begin
         s = one; a.clamped = 1'b1;
      end else if (s < -one) begin
         s = -one; a.clamped = 1'b1;
      end
      sa = (s < 0) ? -s : s;
      c = longint'(isqrt((64'd1 << 60) - sa * sa));
      a.pitch = 15'(atan2_q13(s, c, 12868));
      return a;
   endfunction

   function automatic quat_type unit_quat(real w, real x, real y, real z);
      real n;
      quat_type q;
      n = $sqrt(w * w + x * x + y * y + z * z);
      if (n == 0.0) n = 1.0;
      q.w = 16'($rtoi(w / n * 32767.0));
      q.x = 16'($rtoi(x / n * 32767.0));
      q.y = 16'($rtoi(y / n * 32767.0));
      q.z = 16'($rtoi(z / n * 32767.0));
      return q;
   endfunction

   function automatic real rnd();
      return ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
   endfunction

   function automatic void queue_quat(quat_type q);
      pending_quats = {pending_quats, q};
   endfunction

   // driver
   always @(posedge clock) begin
      quat_type q;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap <= $urandom_range(0, 17);
            req_valid <= 1'b0;
         end else if (pending_quats.size() > 0) begin
            q = pending_quats.pop_front();
            expected_angles = {expected_angles, euler_of(q)};
            req_valid  <= 1'b1;
            req_quat_w <= q.w;
            req_quat_x <= q.x;
            req_quat_y <= q.y;
            req_quat_z <= q.z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      angles_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction roll %0d", rsp_roll_angle);
            end else begin
               e = expected_angles.pop_front();
               if (e.roll !== rsp_roll_angle || e.pitch !== rsp_pitch_angle ||
                   e.yaw !== rsp_yaw_angle || e.clamped !== rsp_pitch_clamped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp r/p/y/c %0d %0d %0d %0d got %0d %0d %0d %0d",
                              e.roll, e.pitch, e.yaw, e.clamped, rsp_roll_angle,
                              rsp_pitch_angle, rsp_yaw_angle, rsp_pitch_clamped);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("quaternion_to_euler_angles test failed");
         $finish;
      end
   end

   initial begin
      quat_type q;
      int k;
      queue_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
      queue_quat('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
      queue_quat('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0});
      queue_quat('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
      queue_quat('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
      queue_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
      queue_quat('{16'sd0, -16'sd32768, 16'sd0, 16'sd0});
      queue_quat('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
      queue_quat('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
      queue_quat('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
      queue_quat('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
      queue_quat('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
      queue_quat('{16'sd23171, 16'sd0, 16'sd23171, 16'sd0});
      queue_quat('{16'sd32767, 16'sd0, 16'sd32767, 16'sd0});
      queue_quat('{16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
      queue_quat('{-16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384});
      queue_quat('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
      queue_quat('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170});
      queue_quat('{16'sd0, 16'sd23170, 16'sd23170, 16'sd0});
      queue_quat('{-16'sd1, 16'sd0, 16'sd0, 16'sd0});
      for (k = 0; k < 950; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               q.w = 16'($urandom); q.x = 16'($urandom);
               q.y = 16'($urandom); q.z = 16'($urandom);
            end
            3: begin
               // near gimbal lock
               q = unit_quat(1.0 + 0.01 * rnd(), 0.01 * rnd(),
                             (($urandom & 1) ? 1.0 : -1.0) + 0.01 * rnd(), 0.01 * rnd());
            end
            default: q = unit_quat(rnd(), rnd(), rnd(), rnd());
         endcase
         queue_quat(q);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_quats.size() < 100);
      quiet = 1'b1;
      wait (pending_quats.size() == 0 && expected_angles.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && expected_angles.size() == 0)
         $display("quaternion_to_euler_angles test passed");
      else
         $display("quaternion_to_euler_angles test failed");
      $finish;
   end

endmodule
